// ===== hw/rtl/tnr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_pkg
// Shared types and constants for the top-N score table ranker: the table
// entry, controller states, read and write selects, and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tnr_pkg;

    localparam int SCORE_W = 24;
    localparam int TAG_W   = 32;
    localparam int LIDX_W  = 3;
    localparam int POS_W   = 3;
    localparam int RANK_W  = 3;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SUBMIT = 1'b1;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HOLD_RD,
        ST_HOLD_LD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_HOLD_WR,
        ST_PICK_RD,
        ST_PICK_LD,
        ST_CMP_RD,
        ST_CMP_CNT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RD_LAST,
        RD_A,
        RD_B,
        RD_P,
        RD_Q
    } rd_src_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_SUB,
        WR_SWAP,
        WR_HOLD
    } wr_src_t;

    typedef struct packed {
        logic    rd_en;
        rd_src_t rd_src;
        wr_src_t wr_src;
        logic    sub_capture;
        logic    check_latch;
        logic    sort_start;
        logic    hold_load;
        logic    scan_step;
        logic    a_step;
        logic    rank_start;
        logic    pick_load;
        logic    cnt_step;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic entered;
        logic a_last;
        logic b_last;
        logic p_zero;
        logic p_last;
        logic q_last;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/tnr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tnr_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 5
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tnr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_datapath
// Table memory with per-entry valid bits, holder and candidate registers,
// sort and rank index counters, rank counter and the output register.
// ----------------------------------------------------------------------------
module tnr_datapath #(
    parameter int ENTRIES = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tnr_pkg::cmd_t                       cmd,
    output tnr_pkg::status_t                    status,
    input  logic [tnr_pkg::LIDX_W-1:0]          load_index,
    input  logic [tnr_pkg::SCORE_W-1:0]         score,
    input  logic [tnr_pkg::TAG_W-1:0]           player_tag,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tnr_pkg::POS_W-1:0]           position,
    output logic [tnr_pkg::RANK_W-1:0]          rank,
    output logic [tnr_pkg::TAG_W-1:0]           entry_tag,
    output logic [tnr_pkg::SCORE_W-1:0]         entry_score,
    output logic                                entered,
    output logic                                last
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] PRE_LAST_IDX = IDX_W'(ENTRIES - 2);
    localparam int EW = $bits(tnr_pkg::entry_t);

    logic [ENTRIES-1:0]             valid_reg;
    logic [ENTRIES-1:0]             valid_next;
    logic                           rdv_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic [IDX_W-1:0]               a_reg;
    logic [IDX_W-1:0]               b_reg;
    logic [IDX_W-1:0]               p_reg;
    logic [IDX_W-1:0]               q_reg;
    logic [tnr_pkg::RANK_W-1:0]     cnt_reg;
    tnr_pkg::entry_t                sub_reg;
    tnr_pkg::entry_t                hold_reg;
    tnr_pkg::entry_t                cur_reg;
    logic                           entered_reg;

    logic [tnr_pkg::POS_W-1:0]      pos_reg;
    logic [tnr_pkg::RANK_W-1:0]     rank_reg;
    tnr_pkg::entry_t                oent_reg;
    logic                           oentered_reg;
    logic                           olast_reg;

    logic [EW-1:0]                  ram_q;
    tnr_pkg::entry_t                rd_ent;
    logic [IDX_W-1:0]               raddr;
    logic [IDX_W-1:0]               waddr;
    tnr_pkg::entry_t                wdata;
    logic                           we;
    logic                           load_ok;
    logic                           le_now;
    logic                           gt_now;

    assign rd_ent  = rdv_reg ? tnr_pkg::entry_t'(ram_q) : '0;
    assign load_ok = 6'(load_index) < 6'(ENTRIES);
    assign le_now  = hold_reg.score <= rd_ent.score;
    assign gt_now  = rd_ent.score > cur_reg.score;

    always_comb
    begin
        unique case (cmd.rd_src)
            tnr_pkg::RD_LAST: raddr = LAST_IDX;
            tnr_pkg::RD_A:    raddr = a_reg;
            tnr_pkg::RD_B:    raddr = b_reg;
            tnr_pkg::RD_P:    raddr = p_reg;
            tnr_pkg::RD_Q:    raddr = q_reg;
            default:          raddr = LAST_IDX;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = LAST_IDX;
        wdata = hold_reg;
        unique case (cmd.wr_src)
            tnr_pkg::WR_LOAD:
            begin
                we    = load_ok;
                waddr = IDX_W'(load_index);
                wdata = '{score: score, tag: player_tag};
            end
            tnr_pkg::WR_SUB:
            begin
                we    = 1'b1;
                waddr = LAST_IDX;
                wdata = sub_reg;
            end
            tnr_pkg::WR_SWAP:
            begin
                we    = le_now;
                waddr = b_reg;
                wdata = hold_reg;
            end
            tnr_pkg::WR_HOLD:
            begin
                we    = 1'b1;
                waddr = a_reg;
                wdata = hold_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    tnr_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cmd.rd_en)
            begin
                rdv_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sub_capture)
        begin
            sub_reg <= '{score: score, tag: player_tag};
        end
        if (cmd.check_latch)
        begin
            entered_reg <= status.entered;
        end
        if (cmd.sort_start)
        begin
            a_reg <= '0;
        end
        else if (cmd.a_step)
        begin
            a_reg <= a_reg + IDX_W'(1);
        end
        if (cmd.hold_load)
        begin
            hold_reg <= rd_ent;
            b_reg    <= a_reg + IDX_W'(1);
        end
        else if (cmd.scan_step)
        begin
            if (le_now)
            begin
                hold_reg <= rd_ent;
            end
            b_reg <= b_reg + IDX_W'(1);
        end
        if (cmd.rank_start)
        begin
            p_reg <= '0;
        end
        else if (cmd.emit)
        begin
            p_reg <= p_reg + IDX_W'(1);
        end
        if (cmd.pick_load)
        begin
            cur_reg <= rd_ent;
            cnt_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.cnt_step)
        begin
            if (gt_now)
            begin
                cnt_reg <= cnt_reg + tnr_pkg::RANK_W'(1);
            end
            q_reg <= q_reg + IDX_W'(1);
        end
        if (cmd.emit)
        begin
            pos_reg      <= tnr_pkg::POS_W'(p_reg);
            rank_reg     <= cnt_reg + tnr_pkg::RANK_W'(1);
            oent_reg     <= cur_reg;
            oentered_reg <= entered_reg;
            olast_reg    <= (p_reg == LAST_IDX);
        end
    end

    assign status.entered  = sub_reg.score > rd_ent.score;
    assign status.a_last   = (a_reg == PRE_LAST_IDX);
    assign status.b_last   = (b_reg == LAST_IDX);
    assign status.p_zero   = (p_reg == '0);
    assign status.p_last   = (p_reg == LAST_IDX);
    assign status.q_last   = (q_reg == (p_reg - IDX_W'(1)));
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign position    = pos_reg;
    assign rank        = rank_reg;
    assign entry_tag   = oent_reg.tag;
    assign entry_score = oent_reg.score;
    assign entered     = oentered_reg;
    assign last        = olast_reg;

endmodule

// ===== hw/rtl/tnr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_ctrl
// Sequencer for load, entry check, exchange sort, rank count and emission
// of the table, one memory access per step.
// ----------------------------------------------------------------------------
module tnr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  tnr_pkg::status_t   status,
    output tnr_pkg::cmd_t      cmd
);

    tnr_pkg::state_t state_reg;
    tnr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tnr_pkg::ST_IDLE:
            begin
                if (in_valid && (kind == tnr_pkg::KIND_SUBMIT))
                begin
                    state_next = tnr_pkg::ST_CHECK;
                end
            end
            tnr_pkg::ST_CHECK:
            begin
                state_next = status.entered ? tnr_pkg::ST_HOLD_RD : tnr_pkg::ST_PICK_RD;
            end
            tnr_pkg::ST_HOLD_RD:  state_next = tnr_pkg::ST_HOLD_LD;
            tnr_pkg::ST_HOLD_LD:  state_next = tnr_pkg::ST_SCAN_RD;
            tnr_pkg::ST_SCAN_RD:  state_next = tnr_pkg::ST_SCAN_CMP;
            tnr_pkg::ST_SCAN_CMP:
            begin
                state_next = status.b_last ? tnr_pkg::ST_HOLD_WR : tnr_pkg::ST_SCAN_RD;
            end
            tnr_pkg::ST_HOLD_WR:
            begin
                state_next = status.a_last ? tnr_pkg::ST_PICK_RD : tnr_pkg::ST_HOLD_RD;
            end
            tnr_pkg::ST_PICK_RD:  state_next = tnr_pkg::ST_PICK_LD;
            tnr_pkg::ST_PICK_LD:
            begin
                state_next = status.p_zero ? tnr_pkg::ST_EMIT : tnr_pkg::ST_CMP_RD;
            end
            tnr_pkg::ST_CMP_RD:   state_next = tnr_pkg::ST_CMP_CNT;
            tnr_pkg::ST_CMP_CNT:
            begin
                state_next = status.q_last ? tnr_pkg::ST_EMIT : tnr_pkg::ST_CMP_RD;
            end
            tnr_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.p_last ? tnr_pkg::ST_IDLE : tnr_pkg::ST_PICK_RD;
                end
            end
            default:              state_next = tnr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            tnr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && (kind == tnr_pkg::KIND_SUBMIT))
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_src      = tnr_pkg::RD_LAST;
                    cmd.sub_capture = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.wr_src = tnr_pkg::WR_LOAD;
                end
            end
            tnr_pkg::ST_CHECK:
            begin
                cmd.check_latch = 1'b1;
                if (status.entered)
                begin
                    cmd.wr_src     = tnr_pkg::WR_SUB;
                    cmd.sort_start = 1'b1;
                end
                else
                begin
                    cmd.rank_start = 1'b1;
                end
            end
            tnr_pkg::ST_HOLD_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = tnr_pkg::RD_A;
            end
            tnr_pkg::ST_HOLD_LD:
            begin
                cmd.hold_load = 1'b1;
            end
            tnr_pkg::ST_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = tnr_pkg::RD_B;
            end
            tnr_pkg::ST_SCAN_CMP:
            begin
                cmd.wr_src    = tnr_pkg::WR_SWAP;
                cmd.scan_step = 1'b1;
            end
            tnr_pkg::ST_HOLD_WR:
            begin
                cmd.wr_src = tnr_pkg::WR_HOLD;
                if (status.a_last)
                begin
                    cmd.rank_start = 1'b1;
                end
                else
                begin
                    cmd.a_step = 1'b1;
                end
            end
            tnr_pkg::ST_PICK_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = tnr_pkg::RD_P;
            end
            tnr_pkg::ST_PICK_LD:
            begin
                cmd.pick_load = 1'b1;
            end
            tnr_pkg::ST_CMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = tnr_pkg::RD_Q;
            end
            tnr_pkg::ST_CMP_CNT:
            begin
                cmd.cnt_step = 1'b1;
            end
            tnr_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/top_n_score_table_ranker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_score_table_ranker
// Keeps a table of ENTRIES score/tag pairs. A load item writes one entry;
// a submit item may replace the last entry and, if it does, re-sorts the
// table; either way it emits every entry with its competition rank.
//
// Input channel: in_valid/in_stall with kind, load_index, score, player_tag.
// Output channel: out_valid/out_stall with position, rank, entry_tag,
// entry_score, entered and last; last marks the final entry of a table.
// A load gives no result; loads beyond the table are dropped. A submit
// reads the last entry, and if it enters runs the exchange sort over the
// table memory, one access per step. Ranking then reads each position p
// and counts the entries before it with a higher score; the entry's rank
// is that count plus one. One item is worked at a time; in_stall is high
// from the submit until the last entry is in the output register, and a
// stalled output holds the sequencer at the next entry. Reset clears the
// table to zero through per-entry valid bits and empties the output
// register.
// ----------------------------------------------------------------------------
module top_n_score_table_ranker #(
    parameter int ENTRIES = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [tnr_pkg::LIDX_W-1:0]  load_index,
    input  logic [tnr_pkg::SCORE_W-1:0] score,
    input  logic [tnr_pkg::TAG_W-1:0]   player_tag,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tnr_pkg::POS_W-1:0]   position,
    output logic [tnr_pkg::RANK_W-1:0]  rank,
    output logic [tnr_pkg::TAG_W-1:0]   entry_tag,
    output logic [tnr_pkg::SCORE_W-1:0] entry_score,
    output logic                        entered,
    output logic                        last
);

    tnr_pkg::cmd_t    cmd;
    tnr_pkg::status_t status;

    tnr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    tnr_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .load_index  (load_index),
        .score       (score),
        .player_tag  (player_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .rank        (rank),
        .entry_tag   (entry_tag),
        .entry_score (entry_score),
        .entered     (entered),
        .last        (last)
    );

endmodule
